FILE: hw/rtl/stencil_3d_apply_core_assert.svh
// Assertion macros shared by the stencil core RTL.
// Depends on aclk and aresetn being visible where the macros are used.
`ifndef STENCIL_3D_APPLY_CORE_ASSERT_SVH
`define STENCIL_3D_APPLY_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define S3D_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication, disabled during reset.
`define S3D_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/s3d_pkg.sv
// Shared types, codes and arithmetic helpers for the 3D stencil core.
// No dependencies.
package s3d_pkg;

    localparam logic ACT_COEF   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [1:0] CFG_DIM_X = 2'd0;
    localparam logic [1:0] CFG_DIM_Y = 2'd1;
    localparam logic [1:0] CFG_DIM_Z = 2'd2;

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] z;
        logic        last;
    } meta_t;

    // Q32.32 sum back to Q16.16: arithmetic shift by 16, then saturate.
    function automatic logic [31:0] sat_q16(input logic signed [63:0] acc);
        logic signed [63:0] sh;
        logic [31:0]        res;
        sh = acc >>> 16;
        if (sh > 64'sd2147483647)
            res = 32'h7FFF_FFFF;
        else if (sh < -64'sd2147483648)
            res = 32'h8000_0000;
        else
            res = sh[31:0];
        return res;
    endfunction

endpackage

FILE: hw/rtl/s3d_ram.sv
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
module s3d_ram #(
    parameter int DW = 32,
    parameter int AW = 10
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read-first: a same-address write shows up on the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hw/rtl/stencil_3d_apply_core.sv
// 3D (2R+1)^3 stencil core: window buffers, multiplier array and adder tree.
// Depends on s3d_pkg, s3d_ram and stencil_3d_apply_core_assert.svh.
// A sample completing a window passes stage 1, products, adder tree and output register.
// Throughput: one item per cycle while the result side is not stalled; every bank RAM has one
// read and one write port, and the (2R+1)^3 multipliers evaluate a whole window each cycle.
// Reset: synchronous active-low; positions clear, extents go to 8, pipeline empties.
// Coefficients and window buffers are not cleared; they are defined once written.
module stencil_3d_apply_core #(
    parameter int RADIUS    = 1,
    parameter int MAX_DIM_X = 256,
    parameter int MAX_DIM_Y = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // coef_index[6:0], coef_value[38:7], sample_value[70:39]
    input  logic        s_tuser,   // action
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // result_value[31:0], out_x[39:32], out_y[47:40], out_z[63:48]
    output logic        m_tlast,   // last_point
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import s3d_pkg::*;

    localparam int SPAN  = 2 * RADIUS + 1;
    localparam int NCOEF = SPAN * SPAN * SPAN;
    localparam int XW    = $clog2(MAX_DIM_X);
    localparam int YW    = $clog2(MAX_DIM_Y);
    localparam int XE    = $clog2(MAX_DIM_X + 1);
    localparam int YE    = $clog2(MAX_DIM_Y + 1);
    localparam int NG    = (MAX_DIM_Y + SPAN - 1) / SPAN;
    localparam int GW    = $clog2(NG);
    localparam int SW    = $clog2(SPAN);
    localparam int AW    = GW + XW;
    localparam int CW    = $clog2(NCOEF);

    // ---------------- handshake ----------------
    logic adv;
    logic s_fire;
    logic is_sample;
    assign adv       = !m_tvalid || m_tready;   // whole pipe moves together
    assign s_tready  = adv;
    assign s_fire    = s_tvalid && s_tready;
    assign is_sample = (s_tuser == ACT_SAMPLE);
    assign cfg_ready = 1'b1;

    logic [6:0]  in_cidx;
    logic [31:0] in_coef;
    logic [31:0] in_samp;
    assign in_cidx = s_tdata[6:0];
    assign in_coef = s_tdata[38:7];
    assign in_samp = s_tdata[70:39];

    // ---------------- extents ----------------
    logic [XE-1:0] ex_reg;
    logic [YE-1:0] ey_reg;
    logic [15:0]   ez_reg;
    logic          cfg_fire;
    logic          cfg_hit;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign cfg_hit  = cfg_fire && (cfg_index == CFG_DIM_X || cfg_index == CFG_DIM_Y ||
                                   cfg_index == CFG_DIM_Z);

    function automatic logic [15:0] clamp16(input logic [15:0] v, input logic [15:0] hi);
        logic [15:0] r;
        if (v < 16'(SPAN))
            r = 16'(SPAN);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
    assign cx = clamp16({7'd0, cfg_data[8:0]}, 16'(MAX_DIM_X));
    assign cy = clamp16({7'd0, cfg_data[8:0]}, 16'(MAX_DIM_Y));
    assign cz = clamp16(cfg_data, 16'hFFFF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_reg <= XE'(8);
            ey_reg <= YE'(8);
            ez_reg <= 16'd8;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                CFG_DIM_X: ex_reg <= cx[XE-1:0];
                CFG_DIM_Y: ey_reg <= cy[YE-1:0];
                CFG_DIM_Z: ez_reg <= cz;
                default: ;
            endcase
        end
    end

    // ---------------- raster position ----------------
    // y and z also kept as slot (mod SPAN) and row group (y div SPAN)
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [15:0]   z_reg, z_next;
    logic [SW-1:0] ys_reg, ys_next;
    logic [GW-1:0] yg_reg, yg_next;
    logic [SW-1:0] zs_reg, zs_next;

    logic x_end, y_end, z_end, emit0;
    assign x_end = (XE'(x_reg) == ex_reg - XE'(1));
    assign y_end = (YE'(y_reg) == ey_reg - YE'(1));
    assign z_end = (z_reg == ez_reg - 16'd1);
    assign emit0 = (XE'(x_reg) >= XE'(2 * RADIUS)) && (YE'(y_reg) >= YE'(2 * RADIUS)) &&
                   (z_reg >= 16'(2 * RADIUS));

    always_comb begin
        x_next  = x_reg;
        y_next  = y_reg;
        z_next  = z_reg;
        ys_next = ys_reg;
        yg_next = yg_reg;
        zs_next = zs_reg;
        if (!x_end) begin
            x_next = x_reg + XW'(1);
        end else begin
            x_next = '0;
            if (!y_end) begin
                y_next = y_reg + YW'(1);
                if (ys_reg == SW'(SPAN - 1)) begin
                    ys_next = '0;
                    yg_next = yg_reg + GW'(1);
                end else begin
                    ys_next = ys_reg + SW'(1);
                end
            end else begin
                y_next  = '0;
                ys_next = '0;
                yg_next = '0;
                if (z_end) begin
                    z_next  = '0;
                    zs_next = '0;
                end else begin
                    z_next  = z_reg + 16'd1;
                    zs_next = (zs_reg == SW'(SPAN - 1)) ? '0 : zs_reg + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            x_reg  <= '0;
            y_reg  <= '0;
            z_reg  <= '0;
            ys_reg <= '0;
            yg_reg <= '0;
            zs_reg <= '0;
        end else if (s_fire && is_sample) begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            ys_reg <= ys_next;
            yg_reg <= yg_next;
            zs_reg <= zs_next;
        end
    end

    // ---------------- coefficients ----------------
    logic [31:0] coef_reg [NCOEF];
    always_ff @(posedge aclk) begin
        if (s_fire && !is_sample && (in_cidx < 7'(NCOEF))) begin
            coef_reg[in_cidx[CW-1:0]] <= in_coef;
        end
    end

    // ---------------- bank RAMs ----------------
    // bank (zs, ys) holds, for each row group and x, the latest sample with that plane and row slot
    logic [31:0] rd [SPAN][SPAN];

    for (genvar bz = 0; bz < SPAN; bz++) begin : g_bz
        for (genvar by = 0; by < SPAN; by++) begin : g_by
            logic          we;
            logic [GW-1:0] grp;
            assign we  = s_fire && is_sample && (zs_reg == SW'(bz)) && (ys_reg == SW'(by));
            // the window row in this slot is in this group or the one before
            assign grp = (SW'(by) <= ys_reg) ? yg_reg : yg_reg - GW'(1);
            s3d_ram #(.DW(32), .AW(AW)) u_bank (
                .aclk  (aclk),
                .we    (we),
                .waddr ({yg_reg, x_reg}),
                .wdata (in_samp),
                .re    (adv),
                .raddr ({grp, x_reg}),
                .rdata (rd[bz][by])
            );
        end
    end

    // ---------------- stage 1: new column ----------------
    logic          smp1_reg;
    logic          emit1_reg;
    logic [31:0]   samp1_reg;
    logic [SW-1:0] zs1_reg;
    logic [SW-1:0] ys1_reg;
    meta_t         meta1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smp1_reg  <= 1'b0;
            emit1_reg <= 1'b0;
        end else if (adv) begin
            smp1_reg  <= s_fire && is_sample;
            emit1_reg <= s_fire && is_sample && emit0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            samp1_reg   <= in_samp;
            zs1_reg     <= zs_reg;
            ys1_reg     <= ys_reg;
            meta1_reg.x <= 8'(XE'(x_reg) - XE'(RADIUS));
            meta1_reg.y <= 8'(YE'(y_reg) - YE'(RADIUS));
            meta1_reg.z <= z_reg - 16'(RADIUS);
            meta1_reg.last <= x_end && y_end && z_end;
        end
    end

    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] s, input int k);
        logic [SW:0] v;
        v = {1'b0, s} + (SW + 1)'(k + 1);   // -2R is +1 modulo SPAN
        if (v >= (SW + 1)'(SPAN))
            v = v - (SW + 1)'(SPAN);
        return v[SW-1:0];
    endfunction

    logic [31:0] col [SPAN][SPAN];
    always_comb begin
        for (int a = 0; a < SPAN; a++) begin
            for (int b = 0; b < SPAN; b++) begin
                if (a == 2 * RADIUS && b == 2 * RADIUS)
                    col[a][b] = samp1_reg;   // current sample, not yet in its bank
                else
                    col[a][b] = rd[slot_of(zs1_reg, a)][slot_of(ys1_reg, b)];
            end
        end
    end

    // window of the older columns, oldest at index 0
    logic [31:0] win_reg [2*RADIUS][SPAN][SPAN];
    always_ff @(posedge aclk) begin
        if (adv && smp1_reg) begin
            for (int c = 0; c < 2 * RADIUS - 1; c++) begin
                win_reg[c] <= win_reg[c + 1];
            end
            win_reg[2*RADIUS-1] <= col;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [63:0] prod_reg [NCOEF];
    logic               emit2_reg;
    meta_t              meta2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < SPAN; a++) begin
                for (int b = 0; b < SPAN; b++) begin
                    for (int c = 0; c < SPAN; c++) begin
                        if (c == 2 * RADIUS)
                            prod_reg[(a*SPAN+b)*SPAN+c] <=
                                $signed(coef_reg[(a*SPAN+b)*SPAN+c]) * $signed(col[a][b]);
                        else
                            prod_reg[(a*SPAN+b)*SPAN+c] <=
                                $signed(coef_reg[(a*SPAN+b)*SPAN+c]) *
                                $signed(win_reg[c][a][b]);
                    end
                end
            end
            meta2_reg <= meta1_reg;
        end
    end

    // ---------------- stages 3-5: adder tree ----------------
    logic signed [63:0] row_reg [SPAN*SPAN];
    logic signed [63:0] pln_reg [SPAN];
    logic signed [63:0] tot_reg;
    logic               emit3_reg, emit4_reg, emit5_reg;
    meta_t              meta3_reg, meta4_reg, meta5_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < SPAN * SPAN; r++) begin
                logic signed [63:0] acc;
                acc = '0;
                for (int c = 0; c < SPAN; c++) begin
                    acc = acc + prod_reg[r*SPAN+c];
                end
                row_reg[r] <= acc;
            end
            for (int p = 0; p < SPAN; p++) begin
                logic signed [63:0] acc2;
                acc2 = '0;
                for (int r = 0; r < SPAN; r++) begin
                    acc2 = acc2 + row_reg[p*SPAN+r];
                end
                pln_reg[p] <= acc2;
            end
            begin
                logic signed [63:0] acc3;
                acc3 = '0;
                for (int p = 0; p < SPAN; p++) begin
                    acc3 = acc3 + pln_reg[p];
                end
                tot_reg <= acc3;
            end
            meta3_reg <= meta2_reg;
            meta4_reg <= meta3_reg;
            meta5_reg <= meta4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit2_reg <= 1'b0;
            emit3_reg <= 1'b0;
            emit4_reg <= 1'b0;
            emit5_reg <= 1'b0;
        end else if (adv) begin
            emit2_reg <= emit1_reg;
            emit3_reg <= emit2_reg;
            emit4_reg <= emit3_reg;
            emit5_reg <= emit4_reg;
        end
    end

    // ---------------- output register ----------------
    logic        oval_reg;
    logic [31:0] ores_reg;
    meta_t       ometa_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oval_reg <= 1'b0;
        end else if (adv) begin
            oval_reg <= emit5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ores_reg  <= sat_q16(tot_reg);
            ometa_reg <= meta5_reg;
        end
    end

    assign m_tvalid = oval_reg;
    assign m_tdata  = {ometa_reg.z, ometa_reg.y, ometa_reg.x, ores_reg};
    assign m_tlast  = ometa_reg.last;

    // ---------------- checks ----------------
`include "stencil_3d_apply_core_assert.svh"
    `S3D_ASSERT_IMP(a_emit_is_sample, emit1_reg, smp1_reg)
    `S3D_ASSERT_IMP(a_x_in_range, 1'b1, XE'(x_reg) < ex_reg)
    `S3D_ASSERT_IMP(a_z_in_range, 1'b1, z_reg < ez_reg)
    `S3D_ASSERT_NXT(a_emit_follows, s_fire && is_sample && emit0, emit1_reg)
    `S3D_ASSERT_NXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

FILE: tb/stencil_3d_apply_checker.sv
`timescale 1ns / 1ps
// Checker for stencil_3d_apply_core: watches the item, result and register channels,
// predicts every result from its own window model and compares. Depends on s3d_pkg.
module stencil_3d_apply_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          n_points
);
    import s3d_pkg::*;

    localparam int SPAN = 3;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] z;
        logic        last;
    } point_t;

    point_t      point_q[$];
    logic [31:0] coefs [SPAN*SPAN*SPAN];
    logic [31:0] planes [SPAN][256][256];
    logic [8:0]  ext_x_reg, ext_y_reg;
    logic [15:0] ext_z_reg;
    int          col, row, pln;

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Q32.32 accumulator back to Q16.16 with saturation.
    function automatic logic [31:0] q16_of(logic signed [63:0] acc);
        logic signed [63:0] sh;
        sh = acc >>> 16;
        if (sh > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (sh < -64'sh8000_0000) return 32'h8000_0000;
        return sh[31:0];
    endfunction

    // Takes one sample, returns 1 with the window sum when a point completes.
    function automatic bit take_sample(logic [31:0] smp, output point_t pt);
        int ex, ey, ez, x, y, z;
        logic signed [63:0] acc;
        bit hit;
        ex = clip(int'(ext_x_reg), SPAN, 256);
        ey = clip(int'(ext_y_reg), SPAN, 256);
        ez = clip(int'(ext_z_reg), SPAN, 65535);
        x = col; y = row; z = pln;
        hit = 0;
        if (x >= ex || y >= ey || z >= ez) begin
            x = 0; y = 0; z = 0;
        end
        planes[z % SPAN][y][x] = smp;
        if (x >= 2 && y >= 2 && z >= 2) begin
            acc = 0;
            for (int k = 0; k < SPAN; k++)
                for (int j = 0; j < SPAN; j++)
                    for (int i = 0; i < SPAN; i++)
                        acc += $signed(coefs[(k*SPAN + j)*SPAN + i])
                             * $signed(planes[(z - 2 + k) % SPAN][y - 2 + j][x - 2 + i]);
            pt.value = q16_of(acc);
            pt.x     = 8'(x - 1);
            pt.y     = 8'(y - 1);
            pt.z     = 16'(z - 1);
            pt.last  = (x == ex - 1) && (y == ey - 1) && (z == ez - 1);
            hit = 1;
        end
        x++;
        if (x >= ex) begin
            x = 0; y++;
            if (y >= ey) begin
                y = 0; z++;
                if (z >= ez) z = 0;
            end
        end
        col = x; row = y; pln = z;
        return hit;
    endfunction

    assign pending = point_q.size();

    always @(posedge aclk) begin
        point_t pt, got;
        if (!aresetn) begin
            point_q.delete();
            ext_x_reg <= 9'd8;
            ext_y_reg <= 9'd8;
            ext_z_reg <= 16'd8;
            col = 0; row = 0; pln = 0;
            errors   = 0;
            n_points = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[39:32], m_tdata[47:40], m_tdata[63:48], m_tlast};
                n_points++;
                if (point_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: actual %h", $time, got);
                end else begin
                    pt = point_q.pop_front();
                    if (got.value !== pt.value) begin
                        errors++;
                        $display("%0t: result_value expected %h actual %h",
                                 $time, pt.value, got.value);
                    end
                    if (got.x !== pt.x || got.y !== pt.y || got.z !== pt.z) begin
                        errors++;
                        $display("%0t: point expected (%0d,%0d,%0d) actual (%0d,%0d,%0d)",
                                 $time, pt.x, pt.y, pt.z, got.x, got.y, got.z);
                    end
                    if (got.last !== pt.last) begin
                        errors++;
                        $display("%0t: last_point expected %b actual %b",
                                 $time, pt.last, got.last);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DIM_X: ext_x_reg <= cfg_data[8:0];
                    CFG_DIM_Y: ext_y_reg <= cfg_data[8:0];
                    CFG_DIM_Z: ext_z_reg <= cfg_data;
                    default: ;
                endcase
                if (cfg_index == CFG_DIM_X || cfg_index == CFG_DIM_Y ||
                    cfg_index == CFG_DIM_Z) begin
                    col = 0; row = 0; pln = 0;
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == ACT_COEF) begin
                    if (s_tdata[6:0] < SPAN*SPAN*SPAN)
                        coefs[s_tdata[4:0]] = s_tdata[38:7];
                end else if (take_sample(s_tdata[70:39], pt)) begin
                    point_q.push_back(pt);
                end
            end
        end
    end
endmodule

FILE: tb/tb_stencil_3d_apply_core.sv
`timescale 1ns / 1ps
// Top testbench for stencil_3d_apply_core: clock, reset, stimulus, verdict.
// Depends on s3d_pkg, the core RTL and stencil_3d_apply_checker.
module tb_stencil_3d_apply_core;
    import s3d_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready, s_tuser;
    logic [71:0] s_tdata;   // coef_index[6:0], coef_value[38:7], sample_value[70:39]
    logic        m_tvalid, m_tready, m_tlast;
    logic [63:0] m_tdata;   // result_value[31:0], out_x[39:32], out_y[47:40], out_z[63:48]
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int errors, pending, n_points;
    int n_items, n_phases;
    bit quiet;              // no idling on either side
    int hold_req, hold_seen;
    int stall_count;

    stencil_3d_apply_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    stencil_3d_apply_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .n_points(n_points)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Result side: random back-pressure, plus a long hold-off on request so
    // the pipeline fills and s_tready drops while items keep coming.
    initial begin
        int hold_left;
        hold_left = 0;
        hold_seen = 0;
        m_tready  = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 0;
            end else begin
                m_tready = quiet ? 1'b1 : ($urandom_range(99) >= 15);
            end
        end
    end

    // Watchdog: cycles with no handshake on any channel.
    initial begin
        stall_count = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", stall_count);
                $display("stencil_3d_apply_core: mismatch");
                $finish;
            end
        end
    end

    // One item; inputs move at the falling edge, handshake seen at the rising edge.
    task automatic send_item(logic act, logic [6:0] idx, logic [31:0] cval, logic [31:0] sval);
        if (!quiet && $urandom_range(99) < 15) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser  = act;
        s_tdata  = {1'b0, sval, cval, idx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 0;
        n_items++;
    endtask

    task automatic load_coef(logic [6:0] idx, logic [31:0] val);
        send_item(ACT_COEF, idx, val, $urandom);
    endtask

    task automatic put_sample(logic [31:0] val);
        send_item(ACT_SAMPLE, 7'($urandom), $urandom, val);
    endtask

    // Wait until every expected point is out, then let the pipe drain.
    task automatic settle();
        wait (pending == 0);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic set_grid(int dx, int dy, int dz);
        settle();
        write_reg(CFG_DIM_X, 16'(dx));
        write_reg(CFG_DIM_Y, 16'(dy));
        write_reg(CFG_DIM_Z, 16'(dz));
        n_phases++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(131071) - 65536;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Raster of samples with occasional coefficient reloads (some out of range).
    task automatic stream_grid(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 8)
                load_coef(7'($urandom_range(127)), pick_value());
            put_sample(pick_value());
        end
    endtask

    initial begin
        int dx, dy, dz;
        aresetn   = 0;
        s_tvalid  = 0;
        s_tuser   = ACT_SAMPLE;
        s_tdata   = '0;
        cfg_valid = 0;
        cfg_index = CFG_DIM_X;
        cfg_data  = '0;
        quiet     = 0;
        hold_req  = 0;
        n_items   = 0;
        n_phases  = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // Every coefficient gets a value before any window is summed.
        for (int i = 0; i < 27; i++)
            load_coef(7'(i), $urandom_range(131071) - 65536);
        // Out-of-range indexes are dropped.
        load_coef(7'd27, 32'h7FFF_FFFF);
        load_coef(7'd127, 32'h8000_0000);

        // Smallest grid: one interior point; extreme samples push saturation.
        set_grid(3, 3, 3);
        for (int i = 0; i < 27; i++)
            put_sample(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
        // Full-scale coefficients, then wrap into a second grid.
        load_coef(7'd13, 32'h7FFF_FFFF);
        load_coef(7'd0, 32'h8000_0000);
        for (int i = 0; i < 27; i++)
            put_sample(32'h7FFF_FFFF);
        for (int i = 0; i < 27; i++)
            put_sample(i[0] ? 32'h0000_0000 : 32'hFFFF_FFFF);

        // Extents below the minimum clamp up to 3.
        set_grid(0, 1, 2);
        quiet = 1;
        stream_grid(27 + 5);
        quiet = 0;

        // Widest x (511 clamps to 256), deepest z; stream past the first row.
        set_grid(511, 3, 65535);
        stream_grid(256 + 20);

        // Back to the reset shape, with a long hold-off on the result side.
        set_grid(8, 8, 8);
        hold_req++;
        stream_grid(8 * 8 * 3);

        // Random small grids, whole and with a spill into the next one.
        while (n_items < 900) begin
            dx = $urandom_range(3, 7);
            dy = $urandom_range(3, 6);
            dz = $urandom_range(3, 5);
            set_grid(dx, dy, dz);
            quiet = ($urandom_range(5) == 0);
            stream_grid(dx * dy * dz + ($urandom_range(1) ? $urandom_range(1, 2 * dx) : 0));
            quiet = 0;
        end

        wait (pending == 0);
        repeat (20) @(negedge aclk);
        $display("covered %0d items over %0d grid settings, %0d points checked",
                 n_items, n_phases, n_points);
        $display("errors: %0d", errors);
        if (errors == 0) begin
            $display("stencil_3d_apply_core: match");
        end else begin
            $display("stencil_3d_apply_core: mismatch");
        end
        $finish;
    end
endmodule
